// ===== src/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

	localparam int QueueDepth = 4;

	localparam int ReadingW = 11;
	localparam int ValueW   = 14;
	localparam int CountW   = 3;
	localparam int IdxW     = 2;

	localparam logic [1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [1:0] KIND_KEY     = 2'd1;
	localparam logic [1:0] KIND_REFRESH = 2'd2;

	localparam logic [1:0] MODE_TWO_DEC = 2'd0;
	localparam logic [1:0] MODE_ONE_DEC = 2'd1;
	localparam logic [1:0] MODE_INT     = 2'd2;

	localparam logic [15:0] REJECT_MASK = 16'hf800;

	// reciprocal of ten, exact for 16-bit dividends
	localparam logic [16:0] RECIP_TEN = 17'd52429;
	localparam int          RECIP_SH  = 19;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic [CountW-1:0] ndig;
		logic              dot_en;
		logic [IdxW-1:0]   dot_idx;
	} tts_job_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'hc0;
			4'd1: code = 8'hf9;
			4'd2: code = 8'ha4;
			4'd3: code = 8'hb0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hf8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = 8'hff;
		endcase
		return code;
	endfunction

endpackage

// ===== src/tts_front.sv =====
`timescale 1ns / 1ps

module tts_front import tts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        push,
	output tts_job_t    push_job,
	input  logic        queue_ready
);

	logic [ReadingW-1:0] reading_q;
	logic [1:0]          mode_q;
	logic                xfer;
	logic [15:0]         r_x25;
	logic [13:0]         r_x5;
	logic [ValueW-1:0]   v;

	assign s_tready = queue_ready;
	assign xfer     = s_tvalid && s_tready;

	assign r_x25 = {reading_q, 4'd0} + {1'b0, reading_q, 3'd0} + {5'd0, reading_q};
	assign r_x5  = {1'b0, reading_q, 2'd0} + {3'd0, reading_q};

	always_comb begin
		v                = '0;
		push_job.ndig    = '0;
		push_job.dot_en  = 1'b0;
		push_job.dot_idx = '0;
		case (mode_q)
			MODE_TWO_DEC: begin
				v                = r_x25[15:2];
				push_job.ndig    = 3'd3 + {2'd0, v >= 14'd1000} + {2'd0, v >= 14'd10000};
				push_job.dot_en  = 1'b1;
				push_job.dot_idx = 2'd2;
			end
			MODE_ONE_DEC: begin
				v                = {3'd0, r_x5[13:3]};
				push_job.ndig    = 3'd2 + {2'd0, v >= 14'd100} + {2'd0, v >= 14'd1000};
				push_job.dot_en  = 1'b1;
				push_job.dot_idx = 2'd1;
			end
			MODE_INT: begin
				v             = {7'd0, reading_q[10:4]};
				push_job.ndig = 3'd1 + {2'd0, v >= 14'd10} + {2'd0, v >= 14'd100};
			end
			default: begin
				v = '0;
			end
		endcase
		push_job.value = v;
	end

	assign push = xfer && s_tuser == KIND_REFRESH && push_job.ndig != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= '0;
			mode_q    <= MODE_TWO_DEC;
		end else if (xfer) begin
			if (s_tuser == KIND_SAMPLE && (s_tdata & REJECT_MASK) == 16'd0) begin
				reading_q <= s_tdata[ReadingW-1:0];
			end
			if (s_tuser == KIND_KEY) begin
				mode_q <= (mode_q == MODE_TWO_DEC) ? MODE_ONE_DEC :
				          (mode_q == MODE_ONE_DEC) ? MODE_INT : MODE_TWO_DEC;
			end
		end
	end

endmodule

// ===== src/tts_queue.sv =====
`timescale 1ns / 1ps

module tts_queue import tts_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tts_job_t push_job,
	output logic     ready,
	input  logic     pop,
	output logic     valid,
	output tts_job_t pop_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	tts_job_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign ready   = count_q != CntW'(DEPTH);
	assign valid   = count_q != '0;
	assign pop_job = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/tts_back.sv =====
`timescale 1ns / 1ps

module tts_back import tts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  tts_job_t    job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	logic              busy_q;
	logic [ValueW-1:0] val_q;
	logic [CountW-1:0] ndig_q;
	logic              dot_en_q;
	logic [IdxW-1:0]   dot_idx_q;
	logic [CountW-1:0] idx_q;
	logic              out_valid_q;
	logic [2:0]        pos_q;
	logic [7:0]        code_q;
	logic              last_q;

	logic              adv;
	logic              emit;
	logic              is_last;
	logic [29:0]       prod;
	logic [ValueW-1:0] quo;
	logic [ValueW-1:0] rem_full;
	logic [7:0]        code;

	assign adv     = !out_valid_q || m_tready;
	assign emit    = busy_q && adv;
	assign is_last = idx_q == ndig_q - 1'b1;
	assign pop     = job_valid && (!busy_q || (emit && is_last));

	// digit = value mod 10 through a reciprocal multiply
	assign prod     = 30'(val_q * RECIP_TEN);
	assign quo      = {3'd0, prod[29:RECIP_SH]};
	assign rem_full = val_q - ((quo << 3) + (quo << 1));
	assign code     = seg_code(rem_full[3:0])
	                  & {~(dot_en_q && idx_q == {1'b0, dot_idx_q}), 7'h7f};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && is_last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			val_q     <= job.value;
			ndig_q    <= job.ndig;
			dot_en_q  <= job.dot_en;
			dot_idx_q <= job.dot_idx;
			idx_q     <= '0;
		end else if (emit) begin
			val_q <= quo;
			idx_q <= idx_q + 1'b1;
		end
		if (emit) begin
			pos_q  <= 3'd7 - idx_q;
			code_q <= code;
			last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, code_q, pos_q};
	assign m_tlast  = last_q;

endmodule

// ===== src/temperature_to_seven_segment.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata                                   | tuser      | tlast
// s_      | in  | [15:0] raw_reading                      | [1:0] kind | -
// m_      | out | [2:0] digit_position, [10:3] segment_code | -          | last
//
// Front takes one transfer per cycle while the job queue has room.
// Back emits one digit per cycle while m_tready does not stall it; a refresh gives n digits (1 to 5).
// Refreshes queue back to back; samples and key presses are taken with no output.
// Reset clears the stored reading, the mode (two decimals) and the queue.
// A stalled output holds its digit; the queue fills before s_tready drops.

module temperature_to_seven_segment import tts_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // raw_reading
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // digit_position, segment_code, zero fill
	output logic        m_tlast
);

	logic     push;
	tts_job_t push_job;
	logic     queue_ready;
	logic     pop;
	logic     job_valid;
	tts_job_t job;

	tts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.push        (push),
		.push_job    (push_job),
		.queue_ready (queue_ready)
	);

	tts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.ready    (queue_ready),
		.pop      (pop),
		.valid    (job_valid),
		.pop_job  (job)
	);

	tts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/tts_checker.sv =====
`timescale 1ns / 1ps

module tts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	logic [2:0] exp_pos_q;
	logic       in_xfer;

	assign in_xfer = s_tvalid && s_tready && s_tdata[0] == 1'b0 && s_tuser[0] == 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q <= 3'd7;
		end else if (m_tvalid && m_tready) begin
			exp_pos_q <= m_tlast ? 3'd7 : m_tdata[2:0] - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] == exp_pos_q)
		else $error("digit position out of sequence");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] >= 3'd3 && m_tdata[15:11] == 5'd0)
		else $error("digit position or padding out of range");

	a_dot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[10] |-> m_tdata[2:0] == 3'd5 || m_tdata[2:0] == 3'd6)
		else $error("decimal point on wrong position");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == 3'd7 && !in_xfer |-> m_tdata[10])
		else $error("decimal point on rightmost digit");

endmodule

bind temperature_to_seven_segment tts_checker u_tts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tts_pkg::*;

	localparam logic [1:0] KindUnused  = 2'd3;
	localparam int         DirectItems = 23;
	localparam int         RandomItems = 410 - DirectItems;
	localparam int         QuietTail   = 60;
	localparam int         DrainCycles = 16;
	localparam int         CycleLimit  = 200000;
	// active-low patterns, digit 0 in the lowest byte
	localparam logic [79:0] SegPatterns = {
		8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
	};

	typedef struct packed {
		logic [2:0] pos;
		logic [7:0] code;
		logic       last;
	} digit_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // raw_reading
	logic [1:0]  s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // digit_position, segment_code, zero fill
	logic        m_tlast;

	digit_t      expected_digits[$];
	digit_t      refresh_digits[$];
	logic [10:0] model_reading;
	logic [1:0]  model_mode;
	int          mismatch_count;
	int          cycle_count;
	int          stall_left;
	bit          idle_on;

	temperature_to_seven_segment i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void light(input logic [2:0] pos, input int unsigned v, input bit dot);
		digit_t d;
		d.pos  = pos;
		d.code = SegPatterns[8 * (v % 10) +: 8];
		if (dot)
			d.code[7] = 1'b0;
		d.last = 1'b0;
		refresh_digits.push_back(d);
	endfunction

	function automatic void predict_digits(input logic [1:0] kind, input logic [15:0] raw);
		int unsigned r;
		int unsigned v;
		r = model_reading;
		refresh_digits.delete();
		case (kind)
			KIND_SAMPLE: begin
				if ((raw & REJECT_MASK) == 16'd0)
					model_reading = raw[10:0];
			end
			KIND_KEY: begin
				model_mode = (model_mode >= MODE_INT) ? MODE_TWO_DEC : model_mode + 2'd1;
			end
			KIND_REFRESH: begin
				case (model_mode)
					MODE_TWO_DEC: begin
						v = (r * 25) >> 2;
						light(3'd7, v, 1'b0);
						light(3'd6, v / 10, 1'b0);
						light(3'd5, v / 100, 1'b1);
						if (v >= 1000)
							light(3'd4, v / 1000, 1'b0);
						if (v >= 10000)
							light(3'd3, v / 10000, 1'b0);
					end
					MODE_ONE_DEC: begin
						v = (r * 5) >> 3;
						light(3'd7, v, 1'b0);
						light(3'd6, v / 10, 1'b1);
						if (v >= 100)
							light(3'd5, v / 100, 1'b0);
						if (v >= 1000)
							light(3'd4, v / 1000, 1'b0);
					end
					MODE_INT: begin
						v = r >> 4;
						light(3'd7, v, 1'b0);
						if (v >= 10)
							light(3'd6, v / 10, 1'b0);
						if (v >= 100)
							light(3'd5, v / 100, 1'b0);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (refresh_digits.size() > 0)
			refresh_digits[refresh_digits.size() - 1].last = 1'b1;
		foreach (refresh_digits[i])
			expected_digits.push_back(refresh_digits[i]);
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [15:0] raw);
		int gap;
		gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(12, 1) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= raw;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_digits(kind, raw);
	endtask

	// output side stalls in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(7) == 0) begin
			stall_left = $urandom_range(12, 1) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		digit_t got;
		digit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pos  = m_tdata[2:0];
			got.code = m_tdata[10:3];
			got.last = m_tlast;
			if (expected_digits.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transfer: pos %0d code %h last %b",
						got.pos, got.code, got.last);
			end else begin
				want = expected_digits.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("digit differs: expected pos %0d code %h last %b, got pos %0d code %h last %b",
							want.pos, want.code, want.last, got.pos, got.code, got.last);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	task automatic test_reset_state();
		send_item(KIND_REFRESH, 16'h0000);
	endtask

	task automatic test_unused_kind();
		send_item(KindUnused, 16'hffff);
		send_item(KIND_REFRESH, 16'hffff);
	endtask

	task automatic test_sample_filter();
		send_item(KIND_SAMPLE, 16'h07ff);
		send_item(KIND_REFRESH, 16'h0000);
		send_item(KIND_SAMPLE, 16'h0800);
		send_item(KIND_SAMPLE, 16'hffff);
		send_item(KIND_SAMPLE, 16'hf800);
		send_item(KIND_REFRESH, 16'h0000);
	endtask

	// reading just below and at the points where extra digits appear
	task automatic test_blanking();
		send_item(KIND_SAMPLE, 16'd159);
		send_item(KIND_REFRESH, 16'h0000);
		send_item(KIND_SAMPLE, 16'd160);
		send_item(KIND_REFRESH, 16'h0000);
		send_item(KIND_SAMPLE, 16'd1599);
		send_item(KIND_REFRESH, 16'h0000);
		send_item(KIND_SAMPLE, 16'd1600);
		send_item(KIND_REFRESH, 16'h0000);
	endtask

	task automatic test_mode_cycle();
		repeat (3) begin
			send_item(KIND_KEY, 16'h0000);
			send_item(KIND_REFRESH, 16'h0000);
		end
	endtask

	task automatic test_random_traffic();
		int          counted;
		int          next_switch;
		int          pick;
		logic [1:0]  kind;
		logic [15:0] raw;
		counted     = 0;
		next_switch = 0;
		while (counted < RandomItems) begin
			if (counted >= next_switch) begin
				idle_on     = ($urandom_range(3) != 0);
				next_switch = counted + 50;
			end
			if (counted >= RandomItems - QuietTail)
				idle_on = 1'b0;
			pick = $urandom_range(99);
			raw  = 16'($urandom);
			if (pick < 50) begin
				kind = KIND_REFRESH;
			end else if (pick < 65) begin
				kind = KIND_KEY;
			end else if (pick < 95) begin
				kind = KIND_SAMPLE;
				if (pick < 88) begin
					case ($urandom_range(9))
						0: raw = 16'd0;
						1: raw = 16'd159;
						2: raw = 16'd160;
						3: raw = 16'd1599;
						4: raw = 16'd1600;
						5: raw = 16'd2047;
						default: raw = {5'd0, raw[10:0]};
					endcase
				end else begin
					raw[15:11] = 5'($urandom_range(31, 1));
				end
			end else begin
				kind = KindUnused;
			end
			send_item(kind, raw);
			counted++;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 16'h0000;
		s_tuser        = KIND_SAMPLE;
		m_tready       = 1'b0;
		mismatch_count = 0;
		stall_left     = 0;
		idle_on        = 1'b1;
		model_reading  = 11'd0;
		model_mode     = MODE_TWO_DEC;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_unused_kind();
		test_sample_filter();
		test_blanking();
		test_mode_cycle();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_digits.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (expected_digits.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
